// File: hdl/cfwr_pkg.sv
// shared types and codes for the circular fifo with rotate
package cfwr_pkg;

  localparam int OPCODE_W = 2;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int INDEX_W  = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_ROTATE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

endpackage

// File: hdl/circular_fifo_with_rotate.sv
// circular fifo with push, pop, peek and rotate on one slot memory
//
//   channel   handshake          fields
//   input     start / busy       in_opcode, in_push_data
//   result    out_valid strobe   out_read_data, out_status, out_fill_count,
//                                out_is_empty, out_is_full, out_head_index,
//                                out_tail_index
//
// a beat is accepted in the idle state, where the accept edge reads the head
// slot; the exec state applies the operation and writes the slot memory back
// the result strobes in the cycle after exec; a new beat may be accepted then
// busy is high during exec, so no new beat is taken before the last one is
// applied; the head slot read is registered ahead of the read-modify-write
// synchronous reset clears head, count, state and strobe; slots stay undefined
// the receiver cannot stall: each result is shown for exactly one cycle
module circular_fifo_with_rotate
  import cfwr_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [WORD_W-1:0]   in_push_data,
  output logic                out_valid,
  output logic [WORD_W-1:0]   out_read_data,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_fill_count,
  output logic                out_is_empty,
  output logic                out_is_full,
  output logic [INDEX_W-1:0]  out_head_index,
  output logic [INDEX_W-1:0]  out_tail_index
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SUMW = AW + 1;
  // only the low port bits of a word can ever be stored
  localparam int SW   = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

  localparam logic [SUMW-1:0] DEPTH_S = SUMW'(DEPTH);
  localparam logic [CW-1:0]   DEPTH_C = CW'(DEPTH);

  // sum of index and count, known below twice the depth
  function automatic logic [AW-1:0] wrap_idx(input logic [SUMW-1:0] v);
    logic [SUMW-1:0] r;
    r = (v >= DEPTH_S) ? v - DEPTH_S : v;
    return r[AW-1:0];
  endfunction

  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] rd_q;

  state_t        state_r, state_nxt;
  op_t           op_r;
  logic [SW-1:0] data_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic          accept;
  logic          exec;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_data;
  logic [SW-1:0] rd_val;
  status_t       status_nxt;
  logic [AW-1:0] tail_nxt;
  logic [SUMW-1:0] end_sum;
  logic [SUMW-1:0] tail_sum;

  logic                out_valid_r;
  logic [WORD_W-1:0]   out_read_data_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_fill_count_r;
  logic                out_is_empty_r;
  logic                out_is_full_r;
  logic [INDEX_W-1:0]  out_head_index_r;
  logic [INDEX_W-1:0]  out_tail_index_r;

  assign accept = start && !busy;
  assign exec   = (state_r == S_EXEC);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    unique case (state_r)
      S_IDLE:  busy = 1'b0;
      S_EXEC:  busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_opcode);
      data_r <= in_push_data[SW-1:0];
    end
  end

  // head slot is read at the accept edge; writes land only at the exec edge,
  // and busy keeps those edges apart, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= mem[head_r];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // slot just past the tail
  assign end_sum = SUMW'(head_r) + SUMW'(count_r);
  assign wr_addr = wrap_idx(end_sum);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rd_val     = '0;
    wr_en      = 1'b0;
    wr_data    = data_r;
    if (exec) begin
      if (op_r == OP_PUSH) begin
        if (count_r >= DEPTH_C) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end else if (count_r == '0) begin
        status_nxt = ST_UNDERFLOW;
      end else begin
        case (op_r)
          OP_POP: begin
            rd_val    = rd_q;
            head_nxt  = wrap_idx(SUMW'(head_r) + SUMW'(1));
            count_nxt = count_r - CW'(1);
          end
          OP_PEEK: begin
            rd_val = rd_q;
          end
          default: begin
            // rotate; when full the target is the head slot itself
            if (count_r > CW'(1)) begin
              wr_en    = 1'b1;
              wr_data  = rd_q;
              head_nxt = wrap_idx(SUMW'(head_r) + SUMW'(1));
            end
          end
        endcase
      end
    end
  end

  assign tail_sum = SUMW'(head_nxt) + SUMW'(count_nxt) - SUMW'(1);
  assign tail_nxt = (count_nxt == '0) ? '0 : wrap_idx(tail_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_read_data_r  <= WORD_W'(rd_val);
      out_status_r     <= status_nxt;
      out_fill_count_r <= COUNT_W'(count_nxt);
      out_is_empty_r   <= (count_nxt == '0);
      out_is_full_r    <= (count_nxt == DEPTH_C);
      out_head_index_r <= INDEX_W'(head_nxt);
      out_tail_index_r <= INDEX_W'(tail_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_count_r;
  assign out_is_empty   = out_is_empty_r;
  assign out_is_full    = out_is_full_r;
  assign out_head_index = out_head_index_r;
  assign out_tail_index = out_tail_index_r;

  a_accept_execs: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> exec)
    else $error("accepted beat did not reach exec");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(exec))
    else $error("result strobe without a preceding exec cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("fill count above depth");

  a_fail_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (status_nxt != ST_OK) |=> $stable(head_r) && $stable(count_r))
    else $error("failed operation changed the queue");

endmodule
